/* rtl/core/rbes_pkg.sv */
package rbes_pkg;

   localparam int FORCE_POINTS_DEF = 2;
   localparam int FRAC_BITS_DEF    = 16;

   localparam int DATA_W  = 32;
   localparam int DT_W    = 17;
   localparam int OPR_W   = 34;
   localparam int PROD_W  = 2 * OPR_W;
   localparam int FIELD_N = 9;
   localparam int BINV_N  = 6;

   // State memory map; the point momenta sit last so that only the depth
   // follows the number of force points.
   localparam int ROT_BASE   = 0;
   localparam int WINV_BASE  = 9;
   localparam int TRANS_BASE = 18;
   localparam int AM_BASE    = 21;
   localparam int W_BASE     = 24;
   localparam int SR_BASE    = 27;
   localparam int T_BASE     = 36;
   localparam int MOM_BASE   = 45;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_XX    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_YY    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_ZZ    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_XY    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_XZ    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_YZ    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_HAS_SHAPE = 3'd6;

   localparam logic OP_STEP   = 1'b0;
   localparam logic OP_REINIT = 1'b1;

   localparam logic [3:0] FLD_TORQUE = 4'd6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_RD,
      ST_MUL,
      ST_ACC,
      ST_WR,
      ST_ORD0,
      ST_ORD1,
      ST_OCAP,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      PH_MOM,
      PH_TRANS,
      PH_AM,
      PH_W,
      PH_SR,
      PH_ROT,
      PH_T,
      PH_WI
   } phase_type;

   typedef enum logic [1:0] {
      A_MEM,
      A_DT,
      A_BINV
   } a_sel_type;

   typedef enum logic [1:0] {
      B_MEM,
      B_ONE,
      B_FIELD,
      B_VSUM
   } b_sel_type;

   typedef struct packed {
      a_sel_type  a_sel;
      logic       a_neg;
      b_sel_type  b_sel;
      logic [3:0] field_idx;
      logic [2:0] binv_idx;
      logic       mul_en;
      logic       acc_en;
      logic       acc_clear;
      logic       wr_en;
      logic       init_wr;
      logic       init_rst;
      logic       vsum_add;
      logic       vsum_clear;
      logic       sat_clear;
      logic       capture;
      logic       cap_lo;
      logic       cap_hi;
   } ctl_type;

   function automatic logic [1:0] inc3(input logic [1:0] x);
      inc3 = (x == 2'd2) ? 2'd0 : x + 2'd1;
   endfunction

   // Register holding element (r, j) of the symmetric body inverse inertia.
   function automatic logic [2:0] binv_index(input logic [1:0] r, input logic [1:0] j);
      logic [2:0] idx;
      idx = 3'(CSR_INV_XX);
      if (r == j) begin
         idx = {1'b0, r};
      end else if ((r == 2'd0 && j == 2'd1) || (r == 2'd1 && j == 2'd0)) begin
         idx = CSR_INV_XY;
      end else if ((r == 2'd0 && j == 2'd2) || (r == 2'd2 && j == 2'd0)) begin
         idx = CSR_INV_XZ;
      end else begin
         idx = CSR_INV_YZ;
      end
      binv_index = idx;
   endfunction

   function automatic logic [1:0] term_count(input phase_type ph);
      logic [1:0] n;
      case (ph)
         PH_W, PH_T, PH_WI: n = 2'd3;
         default:           n = 2'd2;
      endcase
      term_count = n;
   endfunction

   // Row and column of entry idx of a row-major 3x3 matrix.
   function automatic logic [3:0] rc_of9(input logic [3:0] idx);
      logic [3:0] rc;
      case (idx)
         4'd0:    rc = {2'd0, 2'd0};
         4'd1:    rc = {2'd0, 2'd1};
         4'd2:    rc = {2'd0, 2'd2};
         4'd3:    rc = {2'd1, 2'd0};
         4'd4:    rc = {2'd1, 2'd1};
         4'd5:    rc = {2'd1, 2'd2};
         4'd6:    rc = {2'd2, 2'd0};
         4'd7:    rc = {2'd2, 2'd1};
         4'd8:    rc = {2'd2, 2'd2};
         default: rc = {2'd0, 2'd0};
      endcase
      rc_of9 = rc;
   endfunction

endpackage

/* rtl/core/rbes_state_ram.sv */
module rbes_state_ram #(
   parameter int DEPTH  = rbes_pkg::MOM_BASE + 3 * rbes_pkg::FORCE_POINTS_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [ADDR_W-1:0]                  wr_addr,
   input  logic signed [rbes_pkg::DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]                  rd_addr_a,
   input  logic [ADDR_W-1:0]                  rd_addr_b,
   output logic signed [rbes_pkg::DATA_W-1:0] rd_data_a,
   output logic signed [rbes_pkg::DATA_W-1:0] rd_data_b
);

   logic signed [rbes_pkg::DATA_W-1:0] store_ff [DEPTH];
   logic signed [rbes_pkg::DATA_W-1:0] rd_a_ff;
   logic signed [rbes_pkg::DATA_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= store_ff[rd_addr_a];
      rd_b_ff <= store_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

/* rtl/core/rbes_mac.sv */
module rbes_mac #(
   parameter int FRAC_BITS = rbes_pkg::FRAC_BITS_DEF,
   parameter int ADDR_W    = 6
) (
   input  logic                               clock,
   input  logic                               reset,
   input  rbes_pkg::ctl_type                  ctl,
   input  logic signed [rbes_pkg::DATA_W-1:0] rd_data_a,
   input  logic signed [rbes_pkg::DATA_W-1:0] rd_data_b,
   input  logic [ADDR_W-1:0]                  wr_addr,
   input  logic [rbes_pkg::DT_W-1:0]          dt,
   input  logic signed [rbes_pkg::DATA_W-1:0] field_in [rbes_pkg::FIELD_N],
   input  logic signed [rbes_pkg::DATA_W-1:0] binv [rbes_pkg::BINV_N],
   input  logic                               has_shape,
   output logic signed [rbes_pkg::DATA_W-1:0] wr_data,
   output logic                               saturated
);

   localparam int OW = rbes_pkg::OPR_W;
   localparam int PW = rbes_pkg::PROD_W;
   localparam int DW = rbes_pkg::DATA_W;
   localparam logic signed [OW-1:0] ONE = OW'(1) <<< FRAC_BITS;
   localparam logic signed [DW-1:0] ONE_D = DW'(1) <<< FRAC_BITS;
   localparam logic signed [PW-1:0] SAT_HI = {{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}};
   localparam logic signed [PW-1:0] SAT_LO = ~SAT_HI;

   logic [rbes_pkg::DT_W-1:0] dt_ff;
   logic signed [DW-1:0]      field_ff [rbes_pkg::FIELD_N];
   logic signed [OW-1:0]      op_a;
   logic signed [OW-1:0]      op_b;
   logic signed [PW-1:0]      prod_ff;
   logic signed [PW-1:0]      prod_in;
   logic signed [PW-1:0]      acc_ff;
   logic signed [PW-1:0]      acc_in;
   logic signed [OW-1:0]      vsum_ff;
   logic signed [OW-1:0]      vsum_in;
   logic                      sat_ff;
   logic                      sat_in;
   logic signed [DW-1:0]      clamped;
   logic                      over;
   logic signed [DW-1:0]      init_val;
   logic [ADDR_W-1:0]         winv_off;
   logic [3:0]                rc;

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         dt_ff    <= dt;
         field_ff <= field_in;
      end
   end

   always_comb begin
      case (ctl.a_sel)
         rbes_pkg::A_DT:   op_a = OW'(dt_ff);
         rbes_pkg::A_BINV: op_a = OW'(binv[ctl.binv_idx]);
         default:          op_a = ctl.a_neg ? -OW'(rd_data_a) : OW'(rd_data_a);
      endcase
      case (ctl.b_sel)
         rbes_pkg::B_ONE:   op_b = ONE;
         rbes_pkg::B_FIELD: op_b = OW'(field_ff[ctl.field_idx]);
         rbes_pkg::B_VSUM:  op_b = vsum_ff;
         default:           op_b = OW'(rd_data_b);
      endcase
      prod_in = op_a * op_b;
      // Arithmetic shift of the full product rounds toward minus infinity.
      acc_in = prod_ff >>> FRAC_BITS;
      if (!ctl.acc_clear) begin
         acc_in = acc_ff + acc_in;
      end
   end

   always_comb begin
      over = 1'b0;
      if (acc_ff > SAT_HI) begin
         clamped = SAT_HI[DW-1:0];
         over    = 1'b1;
      end else if (acc_ff < SAT_LO) begin
         clamped = SAT_LO[DW-1:0];
         over    = 1'b1;
      end else begin
         clamped = acc_ff[DW-1:0];
      end

      // Values written by the clearing sweep: identity rotation, the world
      // inverse inertia from the body registers (identity after reset, zero without a shape), zero everywhere else.
      winv_off = wr_addr - ADDR_W'(rbes_pkg::WINV_BASE);
      rc       = rbes_pkg::rc_of9(winv_off[3:0]);
      init_val = '0;
      if (wr_addr < ADDR_W'(rbes_pkg::WINV_BASE)) begin
         if (wr_addr == ADDR_W'(0) || wr_addr == ADDR_W'(4) || wr_addr == ADDR_W'(8)) begin
            init_val = ONE_D;
         end
      end else if (wr_addr < ADDR_W'(rbes_pkg::TRANS_BASE)) begin
         if (ctl.init_rst) begin
            init_val = (rc[3:2] == rc[1:0]) ? ONE_D : '0;
         end else if (has_shape) begin
            init_val = binv[rbes_pkg::binv_index(rc[3:2], rc[1:0])];
         end
      end

      wr_data = ctl.init_wr ? init_val : clamped;

      vsum_in = vsum_ff;
      if (ctl.vsum_clear) begin
         vsum_in = '0;
      end else if (ctl.vsum_add) begin
         vsum_in = vsum_ff + OW'(clamped);
      end

      sat_in = sat_ff;
      if (ctl.sat_clear) begin
         sat_in = 1'b0;
      end else if (ctl.wr_en && !ctl.init_wr && over) begin
         sat_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
      if (ctl.acc_en) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vsum_ff <= '0;
         sat_ff  <= 1'b0;
      end else begin
         vsum_ff <= vsum_in;
         sat_ff  <= sat_in;
      end
   end

   assign saturated = sat_ff;

endmodule

/* rtl/core/rbes_sequencer.sv */
module rbes_sequencer #(
   parameter int FORCE_POINTS = rbes_pkg::FORCE_POINTS_DEF,
   parameter int ADDR_W       = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_opcode,
   input  logic [1:0]        req_force_count,
   input  logic              has_shape,
   input  logic              rsp_stall,
   output logic              req_stall,
   output logic              rsp_valid,
   output logic [1:0]        row_index,
   output rbes_pkg::ctl_type ctl,
   output logic [ADDR_W-1:0] addr_a,
   output logic [ADDR_W-1:0] addr_b,
   output logic [ADDR_W-1:0] wr_addr
);

   localparam int DEPTH = rbes_pkg::MOM_BASE + 3 * FORCE_POINTS;
   localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DEPTH - 1);
   localparam logic [1:0] N_MAX = (FORCE_POINTS < 2) ? 2'(FORCE_POINTS) : 2'd2;
   localparam logic [ADDR_W-1:0] THREE = ADDR_W'(3);

   rbes_pkg::state_type state_ff, state_in;
   rbes_pkg::phase_type phase_ff, phase_in;
   logic [1:0]          r_ff, r_in;
   logic [1:0]          c_ff, c_in;
   logic [1:0]          term_ff, term_in;
   logic [1:0]          n_ff, n_in;
   logic                init_rst_ff, init_rst_in;
   logic [ADDR_W-1:0]   sweep_ff, sweep_in;

   logic [1:0]          n_cap;
   logic [1:0]          j;
   logic [1:0]          widx;
   logic [ADDR_W-1:0]   ra, ca, ta, ja, wa;
   logic [ADDR_W-1:0]   dst;
   logic                mat_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= rbes_pkg::ST_INIT;
         phase_ff    <= rbes_pkg::PH_MOM;
         r_ff        <= '0;
         c_ff        <= '0;
         term_ff     <= '0;
         n_ff        <= '0;
         init_rst_ff <= 1'b1;
         sweep_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         r_ff        <= r_in;
         c_ff        <= c_in;
         term_ff     <= term_in;
         n_ff        <= n_in;
         init_rst_ff <= init_rst_in;
         sweep_ff    <= sweep_in;
      end
   end

   always_comb begin
      n_cap = (req_force_count > N_MAX) ? N_MAX : req_force_count;
      ra    = ADDR_W'(r_ff);
      ca    = ADDR_W'(c_ff);
      ta    = ADDR_W'(term_ff);
      // Skew matrix row r has nonzero terms at columns r+1 and r+2 (mod 3).
      j     = (term_ff == 2'd0) ? rbes_pkg::inc3(r_ff) : rbes_pkg::inc3(rbes_pkg::inc3(r_ff));
      widx  = (term_ff == 2'd0) ? rbes_pkg::inc3(rbes_pkg::inc3(r_ff)) : rbes_pkg::inc3(r_ff);
      ja    = ADDR_W'(j);
      wa    = ADDR_W'(widx);
      mat_last = (r_ff == 2'd2) && (c_ff == 2'd2);

      ctl           = '0;
      ctl.a_sel     = rbes_pkg::A_MEM;
      ctl.b_sel     = rbes_pkg::B_MEM;
      addr_a        = '0;
      addr_b        = '0;
      dst           = '0;

      // Operand routing of the current term.
      case (phase_ff)
         rbes_pkg::PH_MOM: begin
            dst = ADDR_W'(rbes_pkg::MOM_BASE) + ca * THREE + ra;
            addr_a = dst;
            ctl.field_idx = 4'(c_ff) * 4'd3 + 4'(r_ff);
            if (term_ff != 2'd0) begin
               ctl.a_sel = rbes_pkg::A_DT;
               ctl.b_sel = rbes_pkg::B_FIELD;
            end else begin
               ctl.b_sel = rbes_pkg::B_ONE;
            end
         end
         rbes_pkg::PH_TRANS: begin
            dst = ADDR_W'(rbes_pkg::TRANS_BASE) + ra;
            addr_a = dst;
            if (term_ff != 2'd0) begin
               ctl.a_sel = rbes_pkg::A_DT;
               ctl.b_sel = rbes_pkg::B_VSUM;
            end else begin
               ctl.b_sel = rbes_pkg::B_ONE;
            end
         end
         rbes_pkg::PH_AM: begin
            dst = ADDR_W'(rbes_pkg::AM_BASE) + ra;
            addr_a = dst;
            ctl.field_idx = rbes_pkg::FLD_TORQUE + 4'(r_ff);
            if (term_ff != 2'd0) begin
               ctl.a_sel = rbes_pkg::A_DT;
               ctl.b_sel = rbes_pkg::B_FIELD;
            end else begin
               ctl.b_sel = rbes_pkg::B_ONE;
            end
         end
         rbes_pkg::PH_W: begin
            dst    = ADDR_W'(rbes_pkg::W_BASE) + ra;
            addr_a = ADDR_W'(rbes_pkg::WINV_BASE) + ra * THREE + ta;
            addr_b = ADDR_W'(rbes_pkg::AM_BASE) + ta;
         end
         rbes_pkg::PH_SR: begin
            dst       = ADDR_W'(rbes_pkg::SR_BASE) + ra * THREE + ca;
            addr_a    = ADDR_W'(rbes_pkg::W_BASE) + wa;
            addr_b    = ADDR_W'(rbes_pkg::ROT_BASE) + ja * THREE + ca;
            ctl.a_neg = (term_ff == 2'd0);
         end
         rbes_pkg::PH_ROT: begin
            dst    = ADDR_W'(rbes_pkg::ROT_BASE) + ra * THREE + ca;
            addr_a = dst;
            addr_b = ADDR_W'(rbes_pkg::SR_BASE) + ra * THREE + ca;
            if (term_ff != 2'd0) begin
               ctl.a_sel = rbes_pkg::A_DT;
            end else begin
               ctl.b_sel = rbes_pkg::B_ONE;
            end
         end
         rbes_pkg::PH_T: begin
            dst          = ADDR_W'(rbes_pkg::T_BASE) + ra * THREE + ca;
            ctl.a_sel    = rbes_pkg::A_BINV;
            ctl.binv_idx = rbes_pkg::binv_index(r_ff, term_ff);
            addr_b       = ADDR_W'(rbes_pkg::ROT_BASE) + ca * THREE + ta;
         end
         default: begin
            dst    = ADDR_W'(rbes_pkg::WINV_BASE) + ra * THREE + ca;
            addr_a = ADDR_W'(rbes_pkg::ROT_BASE) + ra * THREE + ta;
            addr_b = ADDR_W'(rbes_pkg::T_BASE) + ta * THREE + ca;
         end
      endcase

      state_in    = state_ff;
      phase_in    = phase_ff;
      r_in        = r_ff;
      c_in        = c_ff;
      term_in     = term_ff;
      n_in        = n_ff;
      init_rst_in = init_rst_ff;
      sweep_in    = sweep_ff;
      wr_addr     = dst;

      case (state_ff)
         rbes_pkg::ST_IDLE: begin
            if (req_valid) begin
               ctl.capture    = 1'b1;
               ctl.sat_clear  = 1'b1;
               ctl.vsum_clear = 1'b1;
               n_in    = n_cap;
               r_in    = '0;
               c_in    = '0;
               term_in = '0;
               if (req_opcode == rbes_pkg::OP_REINIT) begin
                  state_in    = rbes_pkg::ST_INIT;
                  sweep_in    = '0;
                  init_rst_in = 1'b0;
               end else begin
                  state_in = rbes_pkg::ST_RD;
                  phase_in = (n_cap != 2'd0) ? rbes_pkg::PH_MOM : rbes_pkg::PH_TRANS;
               end
            end
         end
         rbes_pkg::ST_INIT: begin
            ctl.wr_en    = 1'b1;
            ctl.init_wr  = 1'b1;
            ctl.init_rst = init_rst_ff;
            wr_addr      = sweep_ff;
            if (sweep_ff == LAST) begin
               init_rst_in = 1'b0;
               r_in        = '0;
               state_in    = init_rst_ff ? rbes_pkg::ST_IDLE : rbes_pkg::ST_ORD0;
            end else begin
               sweep_in = sweep_ff + ADDR_W'(1);
            end
         end
         rbes_pkg::ST_RD: begin
            state_in = rbes_pkg::ST_MUL;
         end
         rbes_pkg::ST_MUL: begin
            ctl.mul_en = 1'b1;
            state_in   = rbes_pkg::ST_ACC;
         end
         rbes_pkg::ST_ACC: begin
            ctl.acc_en    = 1'b1;
            ctl.acc_clear = (term_ff == 2'd0);
            if (term_ff == rbes_pkg::term_count(phase_ff) - 2'd1) begin
               state_in = rbes_pkg::ST_WR;
            end else begin
               term_in  = term_ff + 2'd1;
               state_in = rbes_pkg::ST_RD;
            end
         end
         rbes_pkg::ST_WR: begin
            ctl.wr_en      = 1'b1;
            ctl.vsum_add   = (phase_ff == rbes_pkg::PH_MOM);
            ctl.vsum_clear = (phase_ff == rbes_pkg::PH_TRANS);
            term_in  = '0;
            state_in = rbes_pkg::ST_RD;
            case (phase_ff)
               rbes_pkg::PH_MOM: begin
                  if (c_ff + 2'd1 < n_ff) begin
                     c_in = c_ff + 2'd1;
                  end else begin
                     c_in     = '0;
                     phase_in = rbes_pkg::PH_TRANS;
                  end
               end
               rbes_pkg::PH_TRANS: begin
                  if (r_ff == 2'd2) begin
                     r_in     = '0;
                     phase_in = rbes_pkg::PH_AM;
                  end else begin
                     r_in     = r_ff + 2'd1;
                     phase_in = (n_ff != 2'd0) ? rbes_pkg::PH_MOM : rbes_pkg::PH_TRANS;
                  end
               end
               rbes_pkg::PH_AM, rbes_pkg::PH_W: begin
                  if (r_ff == 2'd2) begin
                     r_in     = '0;
                     phase_in = (phase_ff == rbes_pkg::PH_AM) ? rbes_pkg::PH_W
                                                              : rbes_pkg::PH_SR;
                  end else begin
                     r_in = r_ff + 2'd1;
                  end
               end
               default: begin
                  if (c_ff == 2'd2) begin
                     c_in = '0;
                     r_in = (r_ff == 2'd2) ? 2'd0 : r_ff + 2'd1;
                  end else begin
                     c_in = c_ff + 2'd1;
                  end
                  if (mat_last) begin
                     case (phase_ff)
                        rbes_pkg::PH_SR: phase_in = rbes_pkg::PH_ROT;
                        rbes_pkg::PH_ROT: begin
                           if (has_shape) begin
                              phase_in = rbes_pkg::PH_T;
                           end else begin
                              state_in = rbes_pkg::ST_ORD0;
                           end
                        end
                        rbes_pkg::PH_T: phase_in = rbes_pkg::PH_WI;
                        default:        state_in = rbes_pkg::ST_ORD0;
                     endcase
                  end
               end
            endcase
         end
         rbes_pkg::ST_ORD0: begin
            addr_a   = ADDR_W'(rbes_pkg::ROT_BASE) + ra * THREE;
            addr_b   = ADDR_W'(rbes_pkg::ROT_BASE) + ra * THREE + ADDR_W'(1);
            state_in = rbes_pkg::ST_ORD1;
         end
         rbes_pkg::ST_ORD1: begin
            ctl.cap_lo = 1'b1;
            addr_a     = ADDR_W'(rbes_pkg::ROT_BASE) + ra * THREE + ADDR_W'(2);
            addr_b     = ADDR_W'(rbes_pkg::TRANS_BASE) + ra;
            state_in   = rbes_pkg::ST_OCAP;
         end
         rbes_pkg::ST_OCAP: begin
            ctl.cap_hi = 1'b1;
            state_in   = rbes_pkg::ST_OUT;
         end
         rbes_pkg::ST_OUT: begin
            if (!rsp_stall) begin
               if (r_ff == 2'd2) begin
                  r_in     = '0;
                  state_in = rbes_pkg::ST_IDLE;
               end else begin
                  r_in     = r_ff + 2'd1;
                  state_in = rbes_pkg::ST_ORD0;
               end
            end
         end
         default: begin
            state_in = rbes_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != rbes_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == rbes_pkg::ST_OUT);
   assign row_index = r_ff;

endmodule

/* rtl/core/rigid_body_euler_step_unit.sv */
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  opcode, dt, force_count, forces, torque
// rsp_      out        rsp_valid/rsp_stall  row_index, last_row, rot_col0..2,
//                                           translation_axis, saturated
// csr_      in         csr_write            csr_index, csr_data
//
// Every product goes through one shared multiplier: a term is read from memory,
// multiplied and accumulated, and each result is then written back. A step
// with a shape also recomputes the world inverse inertia; a reinitialize sweeps
// the state memory. After a step or a reinitialize each of the three rows is
// read and captured and then presented, held while rsp_stall is high.
// After reset a sweep fills the state memory.
module rigid_body_euler_step_unit #(
   parameter int FORCE_POINTS = rbes_pkg::FORCE_POINTS_DEF,
   parameter int FRAC_BITS    = rbes_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_opcode,
   input  logic [rbes_pkg::DT_W-1:0]            req_dt,
   input  logic [1:0]                           req_force_count,
   input  logic signed [rbes_pkg::DATA_W-1:0]   req_force_a_x,
   input  logic signed [rbes_pkg::DATA_W-1:0]   req_force_a_y,
   input  logic signed [rbes_pkg::DATA_W-1:0]   req_force_a_z,
   input  logic signed [rbes_pkg::DATA_W-1:0]   req_force_b_x,
   input  logic signed [rbes_pkg::DATA_W-1:0]   req_force_b_y,
   input  logic signed [rbes_pkg::DATA_W-1:0]   req_force_b_z,
   input  logic signed [rbes_pkg::DATA_W-1:0]   req_torque_x,
   input  logic signed [rbes_pkg::DATA_W-1:0]   req_torque_y,
   input  logic signed [rbes_pkg::DATA_W-1:0]   req_torque_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_row_index,
   output logic                                 rsp_last_row,
   output logic signed [rbes_pkg::DATA_W-1:0]   rsp_rot_col0,
   output logic signed [rbes_pkg::DATA_W-1:0]   rsp_rot_col1,
   output logic signed [rbes_pkg::DATA_W-1:0]   rsp_rot_col2,
   output logic signed [rbes_pkg::DATA_W-1:0]   rsp_translation_axis,
   output logic                                 rsp_saturated,
   input  logic                                 csr_write,
   input  logic [rbes_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rbes_pkg::DATA_W-1:0]          csr_data
);

   localparam int DEPTH  = rbes_pkg::MOM_BASE + 3 * FORCE_POINTS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int DW     = rbes_pkg::DATA_W;
   localparam logic signed [DW-1:0] ONE_D = DW'(1) <<< FRAC_BITS;

   logic signed [DW-1:0] binv_ff [rbes_pkg::BINV_N];
   logic                 has_shape_ff;
   logic signed [DW-1:0] field_vec [rbes_pkg::FIELD_N];
   logic signed [DW-1:0] col0_ff, col1_ff, col2_ff, trans_ff;

   rbes_pkg::ctl_type    ctl;
   logic [ADDR_W-1:0]    addr_a, addr_b, wr_addr;
   logic signed [DW-1:0] rd_data_a, rd_data_b, wr_data;
   logic [1:0]           row_index;
   logic                 saturated;

   always_ff @(posedge clock) begin
      if (reset) begin
         binv_ff[rbes_pkg::CSR_INV_XX] <= ONE_D;
         binv_ff[rbes_pkg::CSR_INV_YY] <= ONE_D;
         binv_ff[rbes_pkg::CSR_INV_ZZ] <= ONE_D;
         binv_ff[rbes_pkg::CSR_INV_XY] <= '0;
         binv_ff[rbes_pkg::CSR_INV_XZ] <= '0;
         binv_ff[rbes_pkg::CSR_INV_YZ] <= '0;
         has_shape_ff                  <= 1'b1;
      end else if (csr_write) begin
         if (csr_index == rbes_pkg::CSR_HAS_SHAPE) begin
            has_shape_ff <= csr_data[0];
         end else if (csr_index < rbes_pkg::CSR_HAS_SHAPE) begin
            binv_ff[csr_index] <= csr_data;
         end
      end
   end

   assign field_vec[0] = req_force_a_x;
   assign field_vec[1] = req_force_a_y;
   assign field_vec[2] = req_force_a_z;
   assign field_vec[3] = req_force_b_x;
   assign field_vec[4] = req_force_b_y;
   assign field_vec[5] = req_force_b_z;
   assign field_vec[6] = req_torque_x;
   assign field_vec[7] = req_torque_y;
   assign field_vec[8] = req_torque_z;

   rbes_sequencer #(
      .FORCE_POINTS (FORCE_POINTS),
      .ADDR_W       (ADDR_W)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_opcode      (req_opcode),
      .req_force_count (req_force_count),
      .has_shape       (has_shape_ff),
      .rsp_stall       (rsp_stall),
      .req_stall       (req_stall),
      .rsp_valid       (rsp_valid),
      .row_index       (row_index),
      .ctl             (ctl),
      .addr_a          (addr_a),
      .addr_b          (addr_b),
      .wr_addr         (wr_addr)
   );

   rbes_state_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock     (clock),
      .wr_en     (ctl.wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (addr_a),
      .rd_addr_b (addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   rbes_mac #(
      .FRAC_BITS (FRAC_BITS),
      .ADDR_W    (ADDR_W)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .wr_addr   (wr_addr),
      .dt        (req_dt),
      .field_in  (field_vec),
      .binv      (binv_ff),
      .has_shape (has_shape_ff),
      .wr_data   (wr_data),
      .saturated (saturated)
   );

   always_ff @(posedge clock) begin
      if (ctl.cap_lo) begin
         col0_ff <= rd_data_a;
         col1_ff <= rd_data_b;
      end
      if (ctl.cap_hi) begin
         col2_ff  <= rd_data_a;
         trans_ff <= rd_data_b;
      end
   end

   assign rsp_row_index        = row_index;
   assign rsp_last_row         = (row_index == 2'd2);
   assign rsp_rot_col0         = col0_ff;
   assign rsp_rot_col1         = col1_ff;
   assign rsp_rot_col2         = col2_ff;
   assign rsp_translation_axis = trans_ff;
   assign rsp_saturated        = saturated;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> req_stall)
      else $error("item accepted while a result is pending");
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second item accepted before the first finished");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_row) |=> !req_stall)
      else $error("block not idle after the last row was taken");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_row_index != 2'd3))
      else $error("row index out of range");
`endif

endmodule
